@@ design/sq3d_pkg.sv @@
package sq3d_pkg;

   // Stored components are offset binary around this value.
   localparam logic signed [15:0] CODE_CENTRE = 16'sd16384;

   // sqrt(2) in Q1.30, rounded.
   localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

   // Half an LSB of the Q1.15 result when the product is taken back from Q.30.
   localparam logic [45:0] SCALE_ROUND = 46'd536870912;

   // One in Q2.30: the radicand starts from here.
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;

   localparam logic [15:0] Q_MAX = 16'd32767;

   // Permutation selector codes.
   localparam logic [1:0] MODE_W_FIRST  = 2'd0;
   localparam logic [1:0] MODE_W_SECOND = 2'd1;
   localparam logic [1:0] MODE_NEGATE   = 2'd2;
   localparam logic [1:0] MODE_W_LAST   = 2'd3;

   // Square root: one result bit per digit step, two radicand bits each.
   localparam int RAD_W  = 32;
   localparam int ROOT_W = 16;
   localparam int REM_W  = 19;
   localparam int ROOT_DIGITS = RAD_W / 2;
   localparam int ROOT_STEPS_PER_STAGE = 2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] qa;
      logic signed [15:0] qb;
      logic signed [15:0] qc;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
   } root_type;

   // One digit of the restoring square root. After all digits, root holds
   // floor(sqrt(rad)) and rem holds rad - root^2.
   function automatic root_type root_step(input root_type cur);
      root_type         nxt;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      begin
         rem_sh = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
         trial  = REM_W'({cur.root, 2'b01});
         nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            nxt.rem  = rem_sh - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
         end else begin
            nxt.rem  = rem_sh;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
         end
         return nxt;
      end
   endfunction

endpackage

@@ design/sq3d_root_stage.sv @@
module sq3d_root_stage #(
   parameter int STEPS = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  sq3d_pkg::side_type in_side,
   input  sq3d_pkg::root_type in_root,
   output logic              out_valid,
   input  logic              out_stall,
   output sq3d_pkg::side_type out_side,
   output sq3d_pkg::root_type out_root
);
   import sq3d_pkg::*;

   logic     valid_ff;
   logic     load;
   side_type side_ff;
   root_type root_ff;
   root_type root_in;

   // The stage takes a new request whenever it is empty or its content moves on.
   assign load     = !valid_ff || !out_stall;
   assign in_stall = !load;

   always_comb begin
      root_in = in_root;
      for (int i = 0; i < STEPS; i++) begin
         root_in = root_step(root_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         side_ff <= in_side;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_root  = root_ff;

endmodule

@@ design/smallest_three_quaternion_decoder.sv @@
// Decodes one smallest-three compressed rotation per clock into signed Q1.15
// x, y, z and w. Each request runs through 4 + ROOT_DIGITS/ROOT_STEPS_PER_STAGE
// register stages (12 with the default of two root digits per stage): scaling
// of the three codes by sqrt(2), squaring, radicand, the digit-by-digit square
// root spread over its stages, and a last stage that rounds, saturates and
// permutes into the output register. A new request is taken every cycle while
// the result side keeps up; a stall on the result side holds only the stages
// that are full, so bubbles ahead of it are still filled.
module smallest_three_quaternion_decoder #(
   parameter int ROOT_STEPS_PER_STAGE = sq3d_pkg::ROOT_STEPS_PER_STAGE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [14:0]        req_code_a,
   input  logic [14:0]        req_code_b,
   input  logic [14:0]        req_code_c,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_comp_x,
   output logic signed [15:0] rsp_comp_y,
   output logic signed [15:0] rsp_comp_z,
   output logic signed [15:0] rsp_comp_w
);
   import sq3d_pkg::*;

   localparam int ROOT_STAGES = ROOT_DIGITS / ROOT_STEPS_PER_STAGE;

   // Recenters a code and scales it by sqrt(2), rounding half away from zero.
   function automatic logic signed [15:0] scale_code(input logic [14:0] code);
      logic signed [15:0] diff;
      logic signed [15:0] neg;
      logic [14:0]        mag;
      logic [45:0]        prod;
      logic [15:0]        mq;
      begin
         diff = $signed({1'b0, code}) - CODE_CENTRE;
         neg  = -diff;
         mag  = diff[15] ? neg[14:0] : diff[14:0];
         prod = 46'(mag) * 46'(SQRT2_Q30) + SCALE_ROUND;
         mq   = prod[45:30];
         return diff[15] ? -$signed(mq) : $signed(mq);
      end
   endfunction

   // Stage 1: scaled components.
   logic     v1_ff;
   logic     en1;
   side_type side1_ff;
   side_type side1_in;

   // Stage 2: squares.
   logic        v2_ff;
   logic        en2;
   side_type    side2_ff;
   logic [29:0] sq_a_ff;
   logic [29:0] sq_b_ff;
   logic [29:0] sq_c_ff;
   logic [31:0] sq_a_in;
   logic [31:0] sq_b_in;
   logic [31:0] sq_c_in;

   // Stage 3: clamped radicand.
   logic        v3_ff;
   logic        en3;
   side_type    side3_ff;
   logic [31:0] rad_ff;
   logic [31:0] sum_in;
   logic [31:0] rad_in;
   root_type    root_start;

   // Square root stages.
   logic     root_valid [0:ROOT_STAGES];
   logic     root_stall [0:ROOT_STAGES];
   side_type root_side  [0:ROOT_STAGES];
   root_type root_data  [0:ROOT_STAGES];

   // Output stage.
   logic               rsp_valid_ff;
   logic               en_out;
   logic signed [15:0] comp_x_ff;
   logic signed [15:0] comp_y_ff;
   logic signed [15:0] comp_z_ff;
   logic signed [15:0] comp_w_ff;
   logic signed [15:0] comp_x_in;
   logic signed [15:0] comp_y_in;
   logic signed [15:0] comp_z_in;
   logic signed [15:0] comp_w_in;
   logic [16:0]        rounded;
   logic signed [15:0] qw;
   side_type           side_last;
   root_type           root_last;

   // Each stage loads when it is empty or when the stage after it loads.
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en3       = !v3_ff || !root_stall[0];
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   // Stage 1.
   assign side1_in.mode = req_mode;
   assign side1_in.qa   = scale_code(req_code_a);
   assign side1_in.qb   = scale_code(req_code_b);
   assign side1_in.qc   = scale_code(req_code_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         side1_ff <= side1_in;
      end
   end

   // Stage 2. Each square is below 2^30.
   assign sq_a_in = $unsigned(32'(side1_ff.qa) * 32'(side1_ff.qa));
   assign sq_b_in = $unsigned(32'(side1_ff.qb) * 32'(side1_ff.qb));
   assign sq_c_in = $unsigned(32'(side1_ff.qc) * 32'(side1_ff.qc));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         side2_ff <= side1_ff;
         sq_a_ff  <= sq_a_in[29:0];
         sq_b_ff  <= sq_b_in[29:0];
         sq_c_ff  <= sq_c_in[29:0];
      end
   end

   // Stage 3. A sum of squares above one leaves nothing for the fourth component.
   assign sum_in = 32'(sq_a_ff) + 32'(sq_b_ff) + 32'(sq_c_ff);
   assign rad_in = (sum_in > ONE_Q30) ? '0 : ONE_Q30 - sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         side3_ff <= side2_ff;
         rad_ff   <= rad_in;
      end
   end

   assign root_start.rad  = rad_ff;
   assign root_start.root = '0;
   assign root_start.rem  = '0;

   assign root_valid[0] = v3_ff;
   assign root_side[0]  = side3_ff;
   assign root_data[0]  = root_start;

   for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
      sq3d_root_stage #(
         .STEPS(ROOT_STEPS_PER_STAGE)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (root_valid[g]),
         .in_stall (root_stall[g]),
         .in_side  (root_side[g]),
         .in_root  (root_data[g]),
         .out_valid(root_valid[g+1]),
         .out_stall(root_stall[g+1]),
         .out_side (root_side[g+1]),
         .out_root (root_data[g+1])
      );
   end

   assign root_stall[ROOT_STAGES] = !en_out;

   // Output stage: round to nearest, saturate, then place the components.
   assign side_last = root_side[ROOT_STAGES];
   assign root_last = root_data[ROOT_STAGES];

   always_comb begin
      rounded = 17'(root_last.root);
      if (17'(root_last.rem) > 17'(root_last.root)) begin
         rounded = rounded + 17'd1;
      end
      qw = (rounded > 17'(Q_MAX)) ? $signed(Q_MAX) : $signed(rounded[15:0]);
   end

   always_comb begin
      case (side_last.mode)
         MODE_W_FIRST: begin
            comp_x_in = qw;
            comp_y_in = side_last.qa;
            comp_z_in = side_last.qb;
            comp_w_in = side_last.qc;
         end
         MODE_W_SECOND: begin
            comp_x_in = side_last.qa;
            comp_y_in = qw;
            comp_z_in = side_last.qb;
            comp_w_in = side_last.qc;
         end
         MODE_NEGATE: begin
            comp_x_in = -side_last.qa;
            comp_y_in = -side_last.qb;
            comp_z_in = -qw;
            comp_w_in = -side_last.qc;
         end
         MODE_W_LAST: begin
            comp_x_in = side_last.qa;
            comp_y_in = side_last.qb;
            comp_z_in = side_last.qc;
            comp_w_in = qw;
         end
         default: begin
            comp_x_in = side_last.qa;
            comp_y_in = side_last.qb;
            comp_z_in = side_last.qc;
            comp_w_in = qw;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= root_valid[ROOT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && root_valid[ROOT_STAGES]) begin
         comp_x_ff <= comp_x_in;
         comp_y_ff <= comp_y_in;
         comp_z_ff <= comp_z_in;
         comp_w_ff <= comp_w_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_comp_x = comp_x_ff;
   assign rsp_comp_y = comp_y_ff;
   assign rsp_comp_z = comp_z_ff;
   assign rsp_comp_w = comp_w_ff;

endmodule

@@ sim/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sq3d_pkg::*;

   localparam int          RANDOM_REQUESTS = 800;
   localparam int          DRAIN_CYCLES    = 24;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam longint      ROOT2_Q30       = 64'd1518500250;
   localparam longint      UNIT_Q30        = 64'd1 << 30;
   localparam longint      COMP_MAX        = 64'd32767;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } rotation_type;

   // One request with the rotation it should decode to. The known flag marks
   // table rows whose rotation is typed in rather than computed.
   typedef struct packed {
      logic [1:0]   mode;
      logic [14:0]  code_a;
      logic [14:0]  code_b;
      logic [14:0]  code_c;
      logic         known;
      rotation_type want;
   } request_type;

   localparam rotation_type NONE = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};

   localparam int NUM_DIRECTED = 20;
   localparam request_type DIRECTED [NUM_DIRECTED] = '{
      // All codes at the centre: the rebuilt component is one and saturates.
      '{MODE_W_LAST,   15'd16384, 15'd16384, 15'd16384, 1'b1,
        '{16'sd0, 16'sd0, 16'sd0, 16'sd32767}},
      '{MODE_W_FIRST,  15'd16384, 15'd16384, 15'd16384, 1'b1,
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd0}},
      '{MODE_W_SECOND, 15'd16384, 15'd16384, 15'd16384, 1'b1,
        '{16'sd0, 16'sd32767, 16'sd0, 16'sd0}},
      '{MODE_NEGATE,   15'd16384, 15'd16384, 15'd16384, 1'b1,
        '{16'sd0, 16'sd0, -16'sd32767, 16'sd0}},
      // All codes at an extreme: the sum of squares exceeds one, so the
      // radicand clamps to zero.
      '{MODE_W_LAST,   15'd0, 15'd0, 15'd0, 1'b1,
        '{-16'sd23170, -16'sd23170, -16'sd23170, 16'sd0}},
      '{MODE_W_FIRST,  15'd0, 15'd0, 15'd0, 1'b1,
        '{16'sd0, -16'sd23170, -16'sd23170, -16'sd23170}},
      '{MODE_NEGATE,   15'd0, 15'd0, 15'd0, 1'b1,
        '{16'sd23170, 16'sd23170, 16'sd0, 16'sd23170}},
      '{MODE_NEGATE,   15'd32767, 15'd32767, 15'd32767, 1'b1,
        '{-16'sd23169, -16'sd23169, 16'sd0, -16'sd23169}},
      '{MODE_W_SECOND, 15'd32767, 15'd32767, 15'd32767, 1'b1,
        '{16'sd23169, 16'sd0, 16'sd23169, 16'sd23169}},
      '{MODE_W_LAST,   15'd32767, 15'd32767, 15'd32767, 1'b1,
        '{16'sd23169, 16'sd23169, 16'sd23169, 16'sd0}},
      '{MODE_W_LAST,   15'd0,     15'd16384, 15'd16384, 1'b0, NONE},
      '{MODE_W_FIRST,  15'd16384, 15'd32767, 15'd16384, 1'b0, NONE},
      '{MODE_W_SECOND, 15'd16384, 15'd16384, 15'd0,     1'b0, NONE},
      '{MODE_NEGATE,   15'd32767, 15'd16384, 15'd16384, 1'b0, NONE},
      '{MODE_W_LAST,   15'd0,     15'd32767, 15'd16384, 1'b0, NONE},
      // In the first two rows below, two extremes leave a radicand just above zero.
      '{MODE_W_LAST,   15'd0,     15'd0,     15'd16384, 1'b0, NONE},
      '{MODE_W_FIRST,  15'd0,     15'd0,     15'd16383, 1'b0, NONE},
      '{MODE_W_SECOND, 15'd16385, 15'd16383, 15'd16384, 1'b0, NONE},
      '{MODE_NEGATE,   15'd24576, 15'd8192,  15'd16384, 1'b0, NONE},
      '{MODE_W_LAST,   15'd16383, 15'd16385, 15'd16386, 1'b0, NONE}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_mode;
   logic [14:0]        req_code_a;
   logic [14:0]        req_code_b;
   logic [14:0]        req_code_c;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_comp_x;
   logic signed [15:0] rsp_comp_y;
   logic signed [15:0] rsp_comp_z;
   logic signed [15:0] rsp_comp_w;

   request_type pending_rotations[$];
   int          mismatches = 0;
   bit          fast_phase = 1'b0;

   smallest_three_quaternion_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_code_a (req_code_a),
      .req_code_b (req_code_b),
      .req_code_c (req_code_c),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_comp_x (rsp_comp_x),
      .rsp_comp_y (rsp_comp_y),
      .rsp_comp_z (rsp_comp_z),
      .rsp_comp_w (rsp_comp_w)
   );

   // Offset-binary code to a signed Q1.15 component, scaled by sqrt(2) and
   // rounded half away from zero.
   function automatic longint scaled_code(input logic [14:0] code);
      longint offset;
      longint mag;
      longint scaled;
      offset = longint'(code) - 16384;
      mag    = (offset < 0) ? -offset : offset;
      scaled = (mag * ROOT2_Q30 + (64'd1 << 29)) >>> 30;
      return (offset < 0) ? -scaled : scaled;
   endfunction

   function automatic longint nearest_root(input longint rad);
      longint root;
      longint trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= rad) begin
            root = trial;
         end
      end
      if (rad - root * root > root) begin
         root = root + 1;
      end
      return root;
   endfunction

   function automatic rotation_type decode_rotation(input logic [1:0] mode,
                                                    input logic [14:0] code_a,
                                                    input logic [14:0] code_b,
                                                    input logic [14:0] code_c);
      rotation_type rot;
      longint       qa;
      longint       qb;
      longint       qc;
      longint       rad;
      longint       qw;
      qa  = scaled_code(code_a);
      qb  = scaled_code(code_b);
      qc  = scaled_code(code_c);
      rad = UNIT_Q30 - (qa * qa + qb * qb + qc * qc);
      if (rad < 0) begin
         rad = 0;
      end
      qw = nearest_root(rad);
      if (qw > COMP_MAX) begin
         qw = COMP_MAX;
      end
      case (mode)
         MODE_W_FIRST: begin
            rot.x = 16'(qw); rot.y = 16'(qa); rot.z = 16'(qb); rot.w = 16'(qc);
         end
         MODE_W_SECOND: begin
            rot.x = 16'(qa); rot.y = 16'(qw); rot.z = 16'(qb); rot.w = 16'(qc);
         end
         MODE_NEGATE: begin
            rot.x = 16'(-qa); rot.y = 16'(-qb); rot.z = 16'(-qw); rot.w = 16'(-qc);
         end
         default: begin
            rot.x = 16'(qa); rot.y = 16'(qb); rot.z = 16'(qc); rot.w = 16'(qw);
         end
      endcase
      return rot;
   endfunction

   // Mostly back to back, often a short gap, now and then a long pause.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Codes spread over the whole range, bunched near the centre, or pinned to
   // an edge, where the radicand runs out, or to the centre code or a neighbour.
   function automatic logic [14:0] random_code();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return 15'($urandom_range(0, 32767));
      end else if (pick < 8) begin
         return 15'(16384 - 256 + $urandom_range(0, 512));
      end
      case ($urandom_range(0, 4))
         0:       return 15'd0;
         1:       return 15'd32767;
         2:       return 15'd16383;
         3:       return 15'd16384;
         default: return 15'd16385;
      endcase
   endfunction

   // Entered and left at a falling edge.
   task automatic send_request(input request_type item);
      int gap;
      gap = fast_phase ? 0 : idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= item.mode;
      req_code_a <= item.code_a;
      req_code_b <= item.code_b;
      req_code_c <= item.code_c;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_rotations = {pending_rotations, item};
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : result_backpressure
      int run;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (reset || fast_phase) begin
            rsp_stall <= 1'b0;
         end else begin
            run = idle_cycles();
            if (run != 0) begin
               rsp_stall <= 1'b1;
               repeat (run) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      request_type  head;
      rotation_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_comp_x, rsp_comp_y, rsp_comp_z, rsp_comp_w};
         if (pending_rotations.size() == 0) begin
            note_mismatch($sformatf("unexpected rotation x=%0d y=%0d z=%0d w=%0d",
                                    got.x, got.y, got.z, got.w));
         end else begin
            head = pending_rotations.pop_front();
            if (got.x !== head.want.x || got.y !== head.want.y ||
                got.z !== head.want.z || got.w !== head.want.w) begin
               note_mismatch($sformatf(
                  "mode %0d codes %0d %0d %0d: want %0d %0d %0d %0d, got %0d %0d %0d %0d",
                  head.mode, head.code_a, head.code_b, head.code_c,
                  head.want.x, head.want.y, head.want.z, head.want.w,
                  got.x, got.y, got.z, got.w));
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      request_type item;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_mode   = MODE_W_FIRST;
      req_code_a = 15'd0;
      req_code_b = 15'd0;
      req_code_c = 15'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         item = DIRECTED[i];
         if (!item.known) begin
            item.want = decode_rotation(item.mode, item.code_a, item.code_b, item.code_c);
         end
         send_request(item);
      end

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         // One stretch runs at full rate on both sides.
         fast_phase  = (n >= 300 && n < 400);
         item.mode   = 2'($urandom_range(0, 3));
         item.code_a = random_code();
         item.code_b = random_code();
         item.code_c = random_code();
         item.known  = 1'b0;
         item.want   = decode_rotation(item.mode, item.code_a, item.code_b, item.code_c);
         send_request(item);
      end
      fast_phase = 1'b0;
      req_valid <= 1'b0;

      while (pending_rotations.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_rotations.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/sq3d_pkg.sv
design/sq3d_root_stage.sv
design/smallest_three_quaternion_decoder.sv
sim/tb_top.sv
